### rtl/cpc_pkg.sv
package cpc_pkg;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FACING_X = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FACING_Z = 3'd4;

	// support bucket limits
	localparam int SUP_COLUMN_V = 8;
	localparam int SUP_NEAR_H   = 1;
	localparam int SUP_RING_H   = 2;
	localparam int SUP_LOW_V    = 2;

	// support bucket, most urgent first
	typedef enum logic [1:0] {
		SUP_COLUMN,
		SUP_NEAR,
		SUP_RING,
		SUP_FAR
	} support_t;

	// facing bucket: cosine at least one half, at least minus one fifth, below
	typedef enum logic [1:0] {
		FAC_AHEAD,
		FAC_SIDE,
		FAC_BEHIND
	} facing_t;

	// result of the key comparison
	typedef enum logic [1:0] {
		ORDER_FIRST,
		ORDER_EQUAL,
		ORDER_SECOND
	} order_t;

endpackage

### rtl/cpc_ifs.sv
// pair of grid coordinates to compare
interface cpc_pair_if #(
	parameter int COORD_BITS = 16
);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] first_z;
	logic signed [COORD_BITS-1:0] second_x;
	logic signed [COORD_BITS-1:0] second_y;
	logic signed [COORD_BITS-1:0] second_z;

	modport source (
		output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		input ready
	);
	modport sink (
		input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		output ready
	);
endinterface

// comparison result
interface cpc_result_if;
	import cpc_pkg::*;

	logic valid;
	logic ready;
	logic first_wins;
	order_t order;

	modport source (
		output valid, first_wins, order,
		input ready
	);
	modport sink (
		input valid, first_wins, order,
		output ready
	);
endinterface

### rtl/chunk_priority_compare_top.sv
// Priority comparator for two grid coordinates. Each word on the pair channel
// carries two coordinates; each gets a key of support bucket, Chebyshev XZ
// distance, facing bucket, vertical distance and Manhattan distance, taken
// relative to the origin and facing registers, and the keys are compared in
// that order. The result word says which coordinate is ahead (or that the keys
// tie). The datapath is a seven-stage pipeline: one pair is taken every cycle
// while the result side is ready. Stages hold their words while the result
// side stalls, and empty stages keep taking words, so the pair channel stays
// ready until the pipeline is full. The facing vector's squared length is kept
// in a register updated in the cycle after a facing write; the cosine tests use
// exact squared products split into partial products over two stages.
module chunk_priority_compare_top #(
	parameter int COORD_BITS = 16,
	parameter int FACING_FRAC_BITS = 14,
	localparam int CfgW = (COORD_BITS > FACING_FRAC_BITS + 2) ?
		COORD_BITS : FACING_FRAC_BITS + 2
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [cpc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input logic [CfgW-1:0] cfg_data,
	cpc_pair_if.sink pair,
	cpc_result_if.source result
);
	import cpc_pkg::*;

	localparam int CB   = COORD_BITS;
	localparam int FW   = FACING_FRAC_BITS + 2;
	localparam int OW   = CB + 1;
	localparam int AW   = OW;
	localparam int MW   = CB + 2;
	localparam int PW   = OW + FW;
	localparam int DOTW = PW + 1;
	localparam int ADW  = DOTW - 1;
	localparam int DW   = 2 * AW;
	localparam int FFW  = 2 * FW;
	localparam int ADL  = ADW / 2;
	localparam int ADH  = ADW - ADL;
	localparam int DL   = DW / 2;
	localparam int DH   = DW - DL;
	localparam int FL   = FFW / 2;
	localparam int FH   = FFW - FL;
	localparam int PLL  = 2 * ADL;
	localparam int PLH  = ADL + ADH;
	localparam int PHH  = 2 * ADH;
	localparam int QLL  = DL + FL;
	localparam int QLH  = DL + FH;
	localparam int QHL  = DH + FL;
	localparam int QHH  = DH + FH;
	localparam int SQW  = 2 * ADW;
	localparam int DFW  = DW + FFW;
	localparam int CW   = SQW + 5;
	localparam int KW   = 4 + 2 * AW + MW;

	function automatic logic [AW-1:0] mag(input logic [OW-1:0] v);
		return v[OW-1] ? AW'(~v + 1'b1) : AW'(v);
	endfunction

	// configuration registers
	logic signed [CB-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic signed [FW-1:0] facing_x_q, facing_z_q;
	logic [FFW-1:0] f2_q;
	logic [FW-1:0] afx, afz;
	logic f_zero;

	assign afx = facing_x_q[FW-1] ? FW'(~facing_x_q + 1'b1) : FW'(facing_x_q);
	assign afz = facing_z_q[FW-1] ? FW'(~facing_z_q + 1'b1) : FW'(facing_z_q);
	assign f_zero = (facing_x_q == '0) && (facing_z_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			facing_x_q <= '0;
			facing_z_q <= '0;
			f2_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_ORIGIN_X: origin_x_q <= cfg_data[CB-1:0];
					CFG_ORIGIN_Y: origin_y_q <= cfg_data[CB-1:0];
					CFG_ORIGIN_Z: origin_z_q <= cfg_data[CB-1:0];
					CFG_FACING_X: facing_x_q <= cfg_data[FW-1:0];
					CFG_FACING_Z: facing_z_q <= cfg_data[FW-1:0];
					default: ;
				endcase
			end
			// squared length of the facing vector
			f2_q <= FFW'(afx) * FFW'(afx) + FFW'(afz) * FFW'(afz);
		end
	end

	// stage handshake: a stage loads when empty or when the next one loads
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6, ld_s7;

	assign ld_s7 = !valid_s7 || result.ready;
	assign ld_s6 = !valid_s6 || ld_s7;
	assign ld_s5 = !valid_s5 || ld_s6;
	assign ld_s4 = !valid_s4 || ld_s5;
	assign ld_s3 = !valid_s3 || ld_s4;
	assign ld_s2 = !valid_s2 || ld_s3;
	assign ld_s1 = !valid_s1 || ld_s2;
	assign pair.ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (ld_s1) valid_s1 <= pair.valid;
			if (ld_s2) valid_s2 <= valid_s1;
			if (ld_s3) valid_s3 <= valid_s2;
			if (ld_s4) valid_s4 <= valid_s3;
			if (ld_s5) valid_s5 <= valid_s4;
			if (ld_s6) valid_s6 <= valid_s5;
			if (ld_s7) valid_s7 <= valid_s6;
		end
	end

	// stage 1: offsets from the origin and their magnitudes
	logic signed [CB-1:0] cx [2];
	logic signed [CB-1:0] cy [2];
	logic signed [CB-1:0] cz [2];
	logic [OW-1:0] ofs_x [2];
	logic [OW-1:0] ofs_y [2];
	logic [OW-1:0] ofs_z [2];

	assign cx[0] = pair.first_x;
	assign cy[0] = pair.first_y;
	assign cz[0] = pair.first_z;
	assign cx[1] = pair.second_x;
	assign cy[1] = pair.second_y;
	assign cz[1] = pair.second_z;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			ofs_x[l] = {cx[l][CB-1], cx[l]} - {origin_x_q[CB-1], origin_x_q};
			ofs_y[l] = {cy[l][CB-1], cy[l]} - {origin_y_q[CB-1], origin_y_q};
			ofs_z[l] = {cz[l][CB-1], cz[l]} - {origin_z_q[CB-1], origin_z_q};
		end
	end

	logic signed [OW-1:0] dx_s1 [2];
	logic signed [OW-1:0] dz_s1 [2];
	logic [AW-1:0] ax_s1 [2];
	logic [AW-1:0] ay_s1 [2];
	logic [AW-1:0] az_s1 [2];
	logic xz0_s1 [2];

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			for (int l = 0; l < 2; l++) begin
				dx_s1[l] <= ofs_x[l];
				dz_s1[l] <= ofs_z[l];
				ax_s1[l] <= mag(ofs_x[l]);
				ay_s1[l] <= mag(ofs_y[l]);
				az_s1[l] <= mag(ofs_z[l]);
				xz0_s1[l] <= (ofs_x[l] == '0) && (ofs_z[l] == '0);
			end
		end
	end

	// stage 2: distances, support bucket and first products
	logic [AW-1:0] h_c [2];
	support_t sup_c [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			h_c[l] = (ax_s1[l] > az_s1[l]) ? ax_s1[l] : az_s1[l];
			if (h_c[l] == '0 && ay_s1[l] <= AW'(SUP_COLUMN_V))
				sup_c[l] = SUP_COLUMN;
			else if (h_c[l] <= AW'(SUP_NEAR_H) && ay_s1[l] <= AW'(SUP_LOW_V))
				sup_c[l] = SUP_NEAR;
			else if (h_c[l] <= AW'(SUP_RING_H) && ay_s1[l] <= AW'(SUP_LOW_V))
				sup_c[l] = SUP_RING;
			else
				sup_c[l] = SUP_FAR;
		end
	end

	support_t sup_s2 [2];
	logic [AW-1:0] h_s2 [2];
	logic [AW-1:0] v_s2 [2];
	logic [MW-1:0] m_s2 [2];
	logic xz0_s2 [2];
	logic signed [PW-1:0] px_s2 [2];
	logic signed [PW-1:0] pz_s2 [2];
	logic [DW-1:0] sqx_s2 [2];
	logic [DW-1:0] sqz_s2 [2];

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			for (int l = 0; l < 2; l++) begin
				sup_s2[l] <= sup_c[l];
				h_s2[l] <= h_c[l];
				v_s2[l] <= ay_s1[l];
				m_s2[l] <= MW'(ax_s1[l]) + MW'(ay_s1[l]) + MW'(az_s1[l]);
				xz0_s2[l] <= xz0_s1[l];
				px_s2[l] <= PW'(dx_s1[l]) * PW'(facing_x_q);
				pz_s2[l] <= PW'(dz_s1[l]) * PW'(facing_z_q);
				sqx_s2[l] <= DW'(ax_s1[l]) * DW'(ax_s1[l]);
				sqz_s2[l] <= DW'(az_s1[l]) * DW'(az_s1[l]);
			end
		end
	end

	// stage 3: dot product and squared XZ length
	logic signed [DOTW-1:0] dot_c [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			dot_c[l] = DOTW'(px_s2[l]) + DOTW'(pz_s2[l]);
		end
	end

	support_t sup_s3 [2];
	logic [AW-1:0] h_s3 [2];
	logic [AW-1:0] v_s3 [2];
	logic [MW-1:0] m_s3 [2];
	logic xz0_s3 [2];
	logic neg_s3 [2];
	logic [ADW-1:0] adot_s3 [2];
	logic [DW-1:0] d_s3 [2];

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			for (int l = 0; l < 2; l++) begin
				sup_s3[l] <= sup_s2[l];
				h_s3[l] <= h_s2[l];
				v_s3[l] <= v_s2[l];
				m_s3[l] <= m_s2[l];
				xz0_s3[l] <= xz0_s2[l];
				neg_s3[l] <= dot_c[l][DOTW-1];
				adot_s3[l] <= dot_c[l][DOTW-1] ? ADW'(-dot_c[l]) : ADW'(dot_c[l]);
				d_s3[l] <= sqx_s2[l] + sqz_s2[l];
			end
		end
	end

	// stage 4: partial products of dot squared and of D times F
	support_t sup_s4 [2];
	logic [AW-1:0] h_s4 [2];
	logic [AW-1:0] v_s4 [2];
	logic [MW-1:0] m_s4 [2];
	logic xz0_s4 [2];
	logic neg_s4 [2];
	logic [PLL-1:0] pll_s4 [2];
	logic [PLH-1:0] plh_s4 [2];
	logic [PHH-1:0] phh_s4 [2];
	logic [QLL-1:0] qll_s4 [2];
	logic [QLH-1:0] qlh_s4 [2];
	logic [QHL-1:0] qhl_s4 [2];
	logic [QHH-1:0] qhh_s4 [2];

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			for (int l = 0; l < 2; l++) begin
				sup_s4[l] <= sup_s3[l];
				h_s4[l] <= h_s3[l];
				v_s4[l] <= v_s3[l];
				m_s4[l] <= m_s3[l];
				xz0_s4[l] <= xz0_s3[l];
				neg_s4[l] <= neg_s3[l];
				pll_s4[l] <= PLL'(adot_s3[l][ADL-1:0]) * PLL'(adot_s3[l][ADL-1:0]);
				plh_s4[l] <= PLH'(adot_s3[l][ADL-1:0]) * PLH'(adot_s3[l][ADW-1:ADL]);
				phh_s4[l] <= PHH'(adot_s3[l][ADW-1:ADL]) * PHH'(adot_s3[l][ADW-1:ADL]);
				qll_s4[l] <= QLL'(d_s3[l][DL-1:0]) * QLL'(f2_q[FL-1:0]);
				qlh_s4[l] <= QLH'(d_s3[l][DL-1:0]) * QLH'(f2_q[FFW-1:FL]);
				qhl_s4[l] <= QHL'(d_s3[l][DW-1:DL]) * QHL'(f2_q[FL-1:0]);
				qhh_s4[l] <= QHH'(d_s3[l][DW-1:DL]) * QHH'(f2_q[FFW-1:FL]);
			end
		end
	end

	// stage 5: sum the partial products
	support_t sup_s5 [2];
	logic [AW-1:0] h_s5 [2];
	logic [AW-1:0] v_s5 [2];
	logic [MW-1:0] m_s5 [2];
	logic xz0_s5 [2];
	logic neg_s5 [2];
	logic [SQW-1:0] dot2_s5 [2];
	logic [DFW-1:0] df_s5 [2];

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			for (int l = 0; l < 2; l++) begin
				sup_s5[l] <= sup_s4[l];
				h_s5[l] <= h_s4[l];
				v_s5[l] <= v_s4[l];
				m_s5[l] <= m_s4[l];
				xz0_s5[l] <= xz0_s4[l];
				neg_s5[l] <= neg_s4[l];
				// cross term appears twice in a square
				dot2_s5[l] <= (SQW'(phh_s4[l]) << (2 * ADL)) +
					(SQW'(plh_s4[l]) << (ADL + 1)) + SQW'(pll_s4[l]);
				df_s5[l] <= (DFW'(qhh_s4[l]) << (DL + FL)) + (DFW'(qhl_s4[l]) << DL) +
					(DFW'(qlh_s4[l]) << FL) + DFW'(qll_s4[l]);
			end
		end
	end

	// stage 6: cosine thresholds and key assembly
	logic [CW-1:0] w4_c [2];
	logic [CW-1:0] w25_c [2];
	logic [CW-1:0] wdf_c [2];
	facing_t fac_c [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			w4_c[l] = CW'(dot2_s5[l]) << 2;
			w25_c[l] = (CW'(dot2_s5[l]) << 4) + (CW'(dot2_s5[l]) << 3) + CW'(dot2_s5[l]);
			wdf_c[l] = CW'(df_s5[l]);
			// offset at the origin counts as straight ahead, no facing as sideways
			if (xz0_s5[l])
				fac_c[l] = FAC_AHEAD;
			else if (f_zero)
				fac_c[l] = FAC_SIDE;
			else if (!neg_s5[l] && w4_c[l] >= wdf_c[l])
				fac_c[l] = FAC_AHEAD;
			else if (!neg_s5[l] || wdf_c[l] >= w25_c[l])
				fac_c[l] = FAC_SIDE;
			else
				fac_c[l] = FAC_BEHIND;
		end
	end

	logic [KW-1:0] key_s6 [2];

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			for (int l = 0; l < 2; l++) begin
				key_s6[l] <= {sup_s5[l], h_s5[l], fac_c[l], v_s5[l], m_s5[l]};
			end
		end
	end

	// stage 7: lexicographic compare as one unsigned compare of packed keys
	logic first_wins_s7;
	order_t order_s7;

	always_ff @(posedge clk) begin
		if (ld_s7) begin
			first_wins_s7 <= key_s6[0] < key_s6[1];
			if (key_s6[0] < key_s6[1])
				order_s7 <= ORDER_FIRST;
			else if (key_s6[0] == key_s6[1])
				order_s7 <= ORDER_EQUAL;
			else
				order_s7 <= ORDER_SECOND;
		end
	end

	assign result.valid = valid_s7;
	assign result.first_wins = first_wins_s7;
	assign result.order = order_s7;

endmodule
